// ===== design/wfdd_pkg.sv =====
package wfdd_pkg;

	localparam int WFDD_SLOTS = 32;

	localparam int SLOT_W     = 5;
	localparam int CRD_W      = 13;
	localparam int EXT_W      = 12;
	localparam int MRG_W      = 7;
	localparam int GEO_W      = 16;
	localparam int S_TDATA_W  = 56;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 56;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int BW_W       = 4;
	localparam int TH_W       = 6;

	localparam logic [BW_W-1:0] BW_RST = 4'd2;
	localparam logic [TH_W-1:0] TH_RST = 6'd20;

	localparam logic [CFG_IDX_W-1:0] REG_BORDER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TITLE  = 2'd1;

	// result kinds, bit positions in the emit mask, in emit order
	localparam int KIND_N  = 6;
	localparam int K_TOP   = 0;
	localparam int K_BOT   = 1;
	localparam int K_LEFT  = 2;
	localparam int K_RIGHT = 3;
	localparam int K_OLD   = 4;
	localparam int K_NEW   = 5;

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] w;
		logic signed [CRD_W-1:0] h;
	} crect_t;

	localparam int CRECT_W = 4 * CRD_W;

	typedef struct packed {
		logic [MRG_W-1:0] l;
		logic [MRG_W-1:0] t;
		logic [MRG_W-1:0] r;
		logic [MRG_W-1:0] b;
	} marg_t;

	typedef struct packed {
		logic signed [GEO_W-1:0] ox;
		logic signed [GEO_W-1:0] oy;
		logic signed [GEO_W-1:0] ow;
		logic signed [GEO_W-1:0] oh;
		logic signed [GEO_W-1:0] ox1;
		logic signed [GEO_W-1:0] oy1;
		logic signed [GEO_W-1:0] nx;
		logic signed [GEO_W-1:0] ny;
		logic signed [GEO_W-1:0] nw;
		logic signed [GEO_W-1:0] nh;
		logic signed [GEO_W-1:0] ix0;
		logic signed [GEO_W-1:0] iy0;
		logic signed [GEO_W-1:0] ix1;
		logic signed [GEO_W-1:0] iy1;
		logic                    same;
		logic [KIND_N-1:0]       mask;
	} geo_t;

endpackage

// ===== design/wfdd_store.sv =====
module wfdd_store import wfdd_pkg::*; #(
	parameter int DEPTH = WFDD_SLOTS,
	parameter int IDX_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  crect_t           wr_data,
	output crect_t           rd_data
);

	logic [CRECT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic [CRECT_W-1:0] rdata_q;
	logic               rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_idx];
			end
		end
	end

	// entries never written read as zero
	assign rd_data = rvld_q ? crect_t'(rdata_q) : '0;

endmodule

// ===== design/wfdd_geom.sv =====
module wfdd_geom import wfdd_pkg::*; (
	input  logic   clk,
	input  crect_t home,
	input  crect_t cont,
	input  marg_t  marg,
	output geo_t   geo
);

	typedef struct packed {
		logic signed [GEO_W-1:0] ox;
		logic signed [GEO_W-1:0] oy;
		logic signed [GEO_W-1:0] ow;
		logic signed [GEO_W-1:0] oh;
		logic signed [GEO_W-1:0] ox1;
		logic signed [GEO_W-1:0] oy1;
		logic signed [GEO_W-1:0] nx;
		logic signed [GEO_W-1:0] ny;
		logic signed [GEO_W-1:0] nw;
		logic signed [GEO_W-1:0] nh;
		logic signed [GEO_W-1:0] nx1;
		logic signed [GEO_W-1:0] ny1;
		logic                    same;
	} frm_t;

	frm_t frm_c, frm_s1;
	geo_t geo_c, geo_s2;

	always_comb begin
		logic signed [GEO_W-1:0] ml, mt, mr, mb;
		logic signed [GEO_W-1:0] hx, hy, hw, hh, cx, cy, cw, ch;
		ml = GEO_W'(marg.l);
		mt = GEO_W'(marg.t);
		mr = GEO_W'(marg.r);
		mb = GEO_W'(marg.b);
		hx = GEO_W'(home.x);
		hy = GEO_W'(home.y);
		hw = GEO_W'(home.w);
		hh = GEO_W'(home.h);
		cx = GEO_W'(cont.x);
		cy = GEO_W'(cont.y);
		cw = GEO_W'(cont.w);
		ch = GEO_W'(cont.h);
		frm_c.ox   = hx - ml;
		frm_c.oy   = hy - mt;
		frm_c.ow   = hw + ml + mr;
		frm_c.oh   = hh + mt + mb;
		frm_c.ox1  = hx + hw + mr;
		frm_c.oy1  = hy + hh + mb;
		frm_c.nx   = cx - ml;
		frm_c.ny   = cy - mt;
		frm_c.nw   = cw + ml + mr;
		frm_c.nh   = ch + mt + mb;
		frm_c.nx1  = cx + cw + mr;
		frm_c.ny1  = cy + ch + mb;
		frm_c.same = (home == cont);
	end

	always_ff @(posedge clk) begin
		frm_s1 <= frm_c;
	end

	always_comb begin
		logic disj;
		geo_c.ox   = frm_s1.ox;
		geo_c.oy   = frm_s1.oy;
		geo_c.ow   = frm_s1.ow;
		geo_c.oh   = frm_s1.oh;
		geo_c.ox1  = frm_s1.ox1;
		geo_c.oy1  = frm_s1.oy1;
		geo_c.nx   = frm_s1.nx;
		geo_c.ny   = frm_s1.ny;
		geo_c.nw   = frm_s1.nw;
		geo_c.nh   = frm_s1.nh;
		geo_c.same = frm_s1.same;
		geo_c.ix0  = (frm_s1.ox > frm_s1.nx) ? frm_s1.ox : frm_s1.nx;
		geo_c.iy0  = (frm_s1.oy > frm_s1.ny) ? frm_s1.oy : frm_s1.ny;
		geo_c.ix1  = (frm_s1.ox1 < frm_s1.nx1) ? frm_s1.ox1 : frm_s1.nx1;
		geo_c.iy1  = (frm_s1.oy1 < frm_s1.ny1) ? frm_s1.oy1 : frm_s1.ny1;
		disj = (geo_c.ix0 >= geo_c.ix1) || (geo_c.iy0 >= geo_c.iy1);
		geo_c.mask          = '0;
		geo_c.mask[K_OLD]   = disj;
		geo_c.mask[K_TOP]   = !disj && (frm_s1.oy < geo_c.iy0);
		geo_c.mask[K_BOT]   = !disj && (frm_s1.oy1 > geo_c.iy1);
		geo_c.mask[K_LEFT]  = !disj && (frm_s1.ox < geo_c.ix0);
		geo_c.mask[K_RIGHT] = !disj && (frm_s1.ox1 > geo_c.ix1);
		geo_c.mask[K_NEW]   = 1'b1;
	end

	always_ff @(posedge clk) begin
		geo_s2 <= geo_c;
	end

	assign geo = geo_s2;

endmodule

// ===== design/window_frame_damage_diff.sv =====
// channel  | dir | handshake          | content
// s_       | in  | s_tvalid/s_tready  | one window per item
// m_       | out | m_tvalid/m_tready  | one rectangle per item, m_tlast on the last one
// cfg_     | in  | cfg_valid/cfg_ready| register writes, always ready
//
// An item passes the store read, frame build and overlap steps, then emits one
// rectangle per cycle while m_ is not stalled, 1 to 5 in all; s_tready stays low until it is done.
// Unchanged content: no rectangles. Out-of-range slot: accepted, no rectangles.
// The store entry is written with the last rectangle; reset empties all entries.
// A stalled m_ holds the current rectangle and pauses the emit sequence.
module window_frame_damage_diff import wfdd_pkg::*; #(
	parameter int WINDOW_SLOTS = WFDD_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // slot, win_x, win_y, win_w, win_h
	input  logic [S_TUSER_W-1:0]  s_tuser,   // is_popup, no_title
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // rect_x, rect_y, rect_w, rect_h
	output logic                  m_tuser,   // clear_background
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int SEL_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_OVL  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;

	logic [BW_W-1:0] bw_q;
	logic [TH_W-1:0] th_q;

	logic [SLOT_W-1:0] in_slot;
	logic [CRD_W-1:0]  in_x, in_y;
	logic [EXT_W-1:0]  in_w, in_h;
	logic              in_popup, in_notitle;
	logic [SEL_W-1:0]  slot_wide;
	logic [IDX_W-1:0]  slot_idx;
	logic              slot_ok;
	logic              s_acc;

	marg_t  marg_c, marg_q;
	crect_t cont_c, cont_q;
	logic [IDX_W-1:0] idx_q;

	crect_t home;
	geo_t   geo;

	logic [KIND_N-1:0] done_q, pending, sel;
	logic              last_c, out_free, emit_go, st_wr;
	logic signed [GEO_W-1:0] rx_c, ry_c, rw_c, rh_c;
	logic              clr_c;

	logic              m_tvalid_q;
	logic [CRD_W-1:0]  rx_q, ry_q;
	logic [EXT_W-1:0]  rw_q, rh_q;
	logic              clr_q, last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= BW_RST;
			th_q <= TH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BORDER: bw_q <= cfg_data[BW_W-1:0];
				REG_TITLE:  th_q <= cfg_data[TH_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_slot    = s_tdata[4:0];
	assign in_x       = s_tdata[17:5];
	assign in_y       = s_tdata[30:18];
	assign in_w       = s_tdata[42:31];
	assign in_h       = s_tdata[54:43];
	assign in_popup   = s_tuser[0];
	assign in_notitle = s_tuser[1];

	assign slot_wide = SEL_W'(in_slot);
	assign slot_idx  = slot_wide[IDX_W-1:0];
	assign slot_ok   = 32'(in_slot) < 32'(WINDOW_SLOTS);
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;

	always_comb begin
		if (in_popup) begin
			marg_c = '{l: MRG_W'(1), t: MRG_W'(1), r: MRG_W'(1), b: MRG_W'(1)};
		end else if (in_notitle) begin
			marg_c = '{l: MRG_W'(bw_q), t: MRG_W'(bw_q), r: MRG_W'(bw_q), b: MRG_W'(bw_q)};
		end else begin
			marg_c = '{l: MRG_W'(bw_q), t: MRG_W'(th_q) + MRG_W'(1),
				r: MRG_W'(bw_q), b: MRG_W'(bw_q)};
		end
		cont_c.x = CRD_W'(in_x + CRD_W'(marg_c.l));
		cont_c.y = CRD_W'(in_y + CRD_W'(marg_c.t));
		cont_c.w = CRD_W'(CRD_W'(in_w) - CRD_W'(marg_c.l) - CRD_W'(marg_c.r));
		cont_c.h = CRD_W'(CRD_W'(in_h) - CRD_W'(marg_c.t) - CRD_W'(marg_c.b));
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			marg_q <= marg_c;
			cont_q <= cont_c;
			idx_q  <= slot_idx;
		end
	end

	wfdd_store #(
		.DEPTH (WINDOW_SLOTS),
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_acc && slot_ok),
		.rd_idx  (slot_idx),
		.wr_en   (st_wr),
		.wr_idx  (idx_q),
		.wr_data (cont_q),
		.rd_data (home)
	);

	wfdd_geom u_geom (
		.clk  (clk),
		.home (home),
		.cont (cont_q),
		.marg (marg_q),
		.geo  (geo)
	);

	assign pending  = geo.mask & ~done_q;
	assign sel      = pending & (~pending + KIND_N'(1));
	assign last_c   = (pending & ~sel) == '0;
	assign out_free = !m_tvalid_q || m_tready;
	assign emit_go  = (state_q == ST_EMIT) && !geo.same && out_free;
	assign st_wr    = emit_go && last_c;

	always_comb begin
		rx_c  = geo.nx;
		ry_c  = geo.ny;
		rw_c  = geo.nw;
		rh_c  = geo.nh;
		clr_c = 1'b1;
		if (sel[K_TOP]) begin
			rx_c = geo.ox;
			ry_c = geo.oy;
			rw_c = geo.ow;
			rh_c = geo.iy0 - geo.oy;
		end else if (sel[K_BOT]) begin
			rx_c = geo.ox;
			ry_c = geo.iy1;
			rw_c = geo.ow;
			rh_c = geo.oy1 - geo.iy1;
		end else if (sel[K_LEFT]) begin
			rx_c = geo.ox;
			ry_c = geo.iy0;
			rw_c = geo.ix0 - geo.ox;
			rh_c = geo.iy1 - geo.iy0;
		end else if (sel[K_RIGHT]) begin
			rx_c = geo.ix1;
			ry_c = geo.iy0;
			rw_c = geo.ox1 - geo.ix1;
			rh_c = geo.iy1 - geo.iy0;
		end else if (sel[K_OLD]) begin
			rx_c = geo.ox;
			ry_c = geo.oy;
			rw_c = geo.ow;
			rh_c = geo.oh;
		end else begin
			clr_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc && slot_ok) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_OVL;
				ST_OVL: begin
					done_q  <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (geo.same || st_wr) begin
						state_q <= ST_IDLE;
					end else if (emit_go) begin
						done_q <= done_q | sel;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			rx_q   <= rx_c[CRD_W-1:0];
			ry_q   <= ry_c[CRD_W-1:0];
			rw_q   <= rw_c[EXT_W-1:0];
			rh_q   <= rh_c[EXT_W-1:0];
			clr_q  <= clr_c;
			last_q <= last_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, rh_q, rw_q, ry_q, rx_q};
	assign m_tuser  = clr_q;
	assign m_tlast  = last_q;

	a_wr_last: assert property (@(posedge clk) disable iff (!arst_n)
		st_wr |=> (m_tvalid && m_tlast))
		else $error("store written without a final rectangle");

	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && !geo.same) |-> (pending != '0))
		else $error("emit state with nothing left to emit");

	a_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && geo.mask[K_OLD]) |-> (geo.mask[K_RIGHT:K_TOP] == '0))
		else $error("strips scheduled for disjoint frames");

endmodule

// ===== dv/tb_window_frame_damage_diff.sv =====
`timescale 1ns / 1ps

module tb_window_frame_damage_diff;
	import wfdd_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0]       slot;
		logic                    popup;
		logic                    notitle;
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic [EXT_W-1:0]        w;
		logic [EXT_W-1:0]        h;
	} window_t;

	typedef struct packed {
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
		logic [EXT_W-1:0] w;
		logic [EXT_W-1:0] h;
		logic             clr;
		logic             last;
	} rect_t;

	class damage_scoreboard;
		int    content[WFDD_SLOTS][4];
		int    border;
		int    title;
		rect_t pending_rects[$];
		int    errors;

		function new();
			foreach (content[i, k]) content[i][k] = 0;
			border = int'(BW_RST);
			title  = int'(TH_RST);
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_BORDER) begin
				border = int'(val[BW_W-1:0]);
			end else if (idx == REG_TITLE) begin
				title = int'(val[TH_W-1:0]);
			end
		endfunction

		function int fold13(int v);
			logic signed [CRD_W-1:0] t;
			t = v[CRD_W-1:0];
			return int'(t);
		endfunction

		function void push_rect(int x, int y, int w, int h, bit clr, bit last);
			rect_t r;
			r.x    = x[CRD_W-1:0];
			r.y    = y[CRD_W-1:0];
			r.w    = w[EXT_W-1:0];
			r.h    = h[EXT_W-1:0];
			r.clr  = clr;
			r.last = last;
			pending_rects.push_back(r);
		endfunction

		// frames are rebuilt with the style and registers in force now
		function void note_window(window_t win);
			int  ml, mt, mr, mb;
			int  c[4];
			int  ox, oy, ow, oh, nx, ny, nw, nh, ix0, iy0, ix1, iy1;
			int  s;
			bit  same;
			s  = int'(win.slot);
			ml = win.popup ? 1 : border;
			mt = win.popup ? 1 : (win.notitle ? border : title + 1);
			mr = ml;
			mb = ml;
			c[0] = fold13(fold13(int'(win.x)) + ml);
			c[1] = fold13(fold13(int'(win.y)) + mt);
			c[2] = fold13(int'(win.w) - ml - mr);
			c[3] = fold13(int'(win.h) - mt - mb);
			same = 1'b1;
			for (int k = 0; k < 4; k++) begin
				if (c[k] != content[s][k]) same = 1'b0;
			end
			if (same) return;
			ox = content[s][0] - ml;
			oy = content[s][1] - mt;
			ow = content[s][2] + ml + mr;
			oh = content[s][3] + mt + mb;
			nx = c[0] - ml;
			ny = c[1] - mt;
			nw = c[2] + ml + mr;
			nh = c[3] + mt + mb;
			ix0 = (ox > nx) ? ox : nx;
			iy0 = (oy > ny) ? oy : ny;
			ix1 = ((ox + ow) < (nx + nw)) ? (ox + ow) : (nx + nw);
			iy1 = ((oy + oh) < (ny + nh)) ? (oy + oh) : (ny + nh);
			if (ix0 >= ix1 || iy0 >= iy1) begin
				push_rect(ox, oy, ow, oh, 1'b1, 1'b0);
			end else begin
				if (oy < iy0) push_rect(ox, oy, ow, iy0 - oy, 1'b1, 1'b0);
				if (oy + oh > iy1) push_rect(ox, iy1, ow, (oy + oh) - iy1, 1'b1, 1'b0);
				if (ox < ix0) push_rect(ox, iy0, ix0 - ox, iy1 - iy0, 1'b1, 1'b0);
				if (ox + ow > ix1) push_rect(ix1, iy0, (ox + ow) - ix1, iy1 - iy0, 1'b1, 1'b0);
			end
			push_rect(nx, ny, nw, nh, 1'b0, 1'b1);
			for (int k = 0; k < 4; k++) content[s][k] = c[k];
		endfunction

		task report_mismatch(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_rect(rect_t got);
			rect_t exp_r;
			string diffs;
			if (pending_rects.size() == 0) begin
				report_mismatch($sformatf("unexpected rect %h", got));
				return;
			end
			exp_r = pending_rects.pop_front();
			diffs = "";
			if (got.x != exp_r.x) diffs = {diffs, $sformatf(" x %h/%h", got.x, exp_r.x)};
			if (got.y != exp_r.y) diffs = {diffs, $sformatf(" y %h/%h", got.y, exp_r.y)};
			if (got.w != exp_r.w) diffs = {diffs, $sformatf(" w %h/%h", got.w, exp_r.w)};
			if (got.h != exp_r.h) diffs = {diffs, $sformatf(" h %h/%h", got.h, exp_r.h)};
			if (got.clr != exp_r.clr) diffs = {diffs, $sformatf(" clr %b/%b", got.clr, exp_r.clr)};
			if (got.last != exp_r.last) diffs = {diffs, $sformatf(" last %b/%b", got.last, exp_r.last)};
			if (diffs != "") report_mismatch({"rect mismatch (got/exp):", diffs});
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;   // slot, win_x, win_y, win_w, win_h
	logic [S_TUSER_W-1:0]  s_tuser = '0;   // is_popup, no_title
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;        // rect_x, rect_y, rect_w, rect_h
	logic                  m_tuser;        // clear_background
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	damage_scoreboard sb;
	window_t          shadow[WFDD_SLOTS];
	bit               idle_on = 1'b1;

	window_frame_damage_diff DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	// result side: random stall bursts, checked at the rising edge
	initial begin
		int    stall;
		rect_t got;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				stall = $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b1;
			end
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.x    = m_tdata[12:0];
				got.y    = m_tdata[25:13];
				got.w    = m_tdata[37:26];
				got.h    = m_tdata[49:38];
				got.clr  = m_tuser;
				got.last = m_tlast;
				sb.check_rect(got);
			end
		end
	end

	function automatic window_t mk(int slot, bit popup, bit notitle, int x, int y, int w, int h);
		window_t win;
		win.slot    = slot[SLOT_W-1:0];
		win.popup   = popup;
		win.notitle = notitle;
		win.x       = x[CRD_W-1:0];
		win.y       = y[CRD_W-1:0];
		win.w       = w[EXT_W-1:0];
		win.h       = h[EXT_W-1:0];
		return win;
	endfunction

	function automatic int jitter();
		return int'($urandom_range(0, 40)) - 20;
	endfunction

	function automatic window_t next_window();
		window_t win;
		int      pick;
		int      s;
		pick = $urandom_range(0, 9);
		s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, WFDD_SLOTS - 1) : $urandom_range(0, 5);
		win = shadow[s];
		if (pick == 0) begin
			win = mk($urandom, 1'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
				$urandom);
		end else if (pick > 1) begin
			case ($urandom_range(0, 3))
				0: win.x = 13'(int'(win.x) + jitter());
				1: win.y = 13'(int'(win.y) + jitter());
				2: begin
					win.w = 12'(int'(win.w) + jitter());
					win.h = 12'(int'(win.h) + jitter());
				end
				default: begin
					win.x = 13'(int'(win.x) + jitter());
					win.y = 13'(int'(win.y) + jitter());
				end
			endcase
			if ($urandom_range(0, 5) == 0) {win.popup, win.notitle} = 2'($urandom);
		end
		return win;
	endfunction

	task automatic send_window(window_t win);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, win.h, win.w, win.y, win.x, win.slot};
		s_tuser  <= {win.notitle, win.popup};
		do @(posedge clk); while (!s_tready);
		sb.note_window(win);
		shadow[win.slot] = win;
	endtask

	task automatic drain_results();
		int guard;
		guard = 0;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_rects.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int count);
		repeat (count) send_window(next_window());
	endtask

	initial begin
		sb = new();
		foreach (shadow[i]) begin
			shadow[i] = mk(i, 1'($urandom), 1'($urandom), int'($urandom_range(0, 400)) - 200,
				int'($urandom_range(0, 400)) - 200, $urandom_range(10, 100),
				$urandom_range(10, 100));
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset register values
		send_window(mk(0, 1, 0, -1, -1, 2, 2));        // matches cleared store
		send_window(mk(0, 1, 0, 10, 10, 20, 20));      // disjoint from old frame
		send_window(mk(0, 1, 0, 12, 8, 20, 20));       // partial overlap
		send_window(mk(0, 1, 0, 5, 5, 40, 40));        // new frame covers old
		send_window(mk(0, 1, 0, 15, 15, 5, 5));        // shrink inside: four strips
		send_window(mk(0, 1, 0, 15, 15, 5, 5));        // unchanged
		send_window(mk(0, 0, 0, 15, 15, 5, 5));        // style change, negative extents
		send_window(mk(0, 0, 1, 15, 15, 5, 5));
		send_window(mk(31, 0, 0, -4096, -4096, 4095, 4095));
		send_window(mk(31, 0, 1, 4095, 4095, 4095, 4095));   // content wraps
		send_window(mk(1, 0, 0, 0, 0, 0, 0));
		send_window(mk(1, 1, 0, 4095, -4096, 0, 4095));
		send_window(mk(2, 1, 1, 100, 100, 50, 50));    // popup wins over no_title
		send_window(mk(2, 0, 1, 100, 100, 50, 50));
		send_window(mk(3, 0, 0, 0, 0, 4, 22));
		send_window(mk(5, 0, 1, 'h0AAA, 'h1555, 'hAAA, 'h555));
		send_window(mk(10, 1, 1, 'h1555, 'h0AAA, 'h555, 'hAAA));
		send_window(mk(0, 1, 0, -1, -1, 2, 2));
		send_window(mk(0, 1, 0, -1, -1, 2, 2));
		random_phase(30);
		drain_results();

		write_reg(REG_BORDER, 6'd0);
		write_reg(REG_TITLE, 6'd0);
		send_window(shadow[0]);
		send_window(mk(4, 0, 0, 4095, 4095, 4095, 4095));
		random_phase(35);
		drain_results();

		write_reg(REG_BORDER, 6'd15);
		write_reg(REG_TITLE, 6'd63);
		send_window(shadow[0]);
		send_window(mk(4, 0, 0, -4096, -4096, 0, 0));
		random_phase(35);
		drain_results();

		write_reg(REG_TITLE, 6'd7);
		write_reg(REG_BORDER, 6'd1);
		idle_on = 1'b0;
		random_phase(30);
		drain_results();

		if (sb.pending_rects.size() != 0) begin
			sb.report_mismatch($sformatf("%0d rects never arrived", sb.pending_rects.size()));
		end
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
